// ===== rtl/counting_semaphore_fifo_waiters_top_assert.svh =====
// Assertion macros shared by the checker of the counting semaphore block.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_TOP_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_TOP_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold at the same edge.
`define CSFW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csfw check failed");

// Whenever the antecedent holds, the consequent must hold at the next edge.
`define CSFW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csfw check failed");

`endif

// ===== rtl/csfw_pkg.sv =====
// Package with the payload types, field widths and status codes of the semaphore block.
package csfw_pkg;

    // Default parameter values.
    localparam int DEF_QUEUE_DEPTH    = 16;
    localparam int DEF_THREAD_ID_BITS = 8;
    localparam int DEF_COUNT_BITS     = 16;

    // Field widths of the transfers.
    localparam int CMD_W     = 1;
    localparam int ID_W      = 8;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 16;
    localparam int WAITERS_W = 5;
    localparam int CFG_W     = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WAIT   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SIGNAL = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BLOCKED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_WOKEN     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_QFULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  thread_id;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ID_W-1:0]      woken_thread;
        logic [COUNT_W-1:0]   count_now;
        logic [WAITERS_W-1:0] waiters_now;
    } out_t;

endpackage

// ===== rtl/csfw_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module csfw_ram #(
    parameter int WIDTH = csfw_pkg::DEF_THREAD_ID_BITS,
    parameter int DEPTH = csfw_pkg::DEF_QUEUE_DEPTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/csfw_ctrl.sv =====
// Semaphore control: count, queue pointers, waiter store access and result assembly.
module csfw_ctrl #(
    parameter int QUEUE_DEPTH    = csfw_pkg::DEF_QUEUE_DEPTH,
    parameter int THREAD_ID_BITS = csfw_pkg::DEF_THREAD_ID_BITS,
    parameter int COUNT_BITS     = csfw_pkg::DEF_COUNT_BITS,
    parameter int PTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  csfw_pkg::in_t               in_item,
    input  logic                        cfg_write_en,
    input  logic [csfw_pkg::CFG_W-1:0]  cfg_write_data,
    output logic                        ram_we,
    output logic [PTR_W-1:0]            ram_waddr,
    output logic [THREAD_ID_BITS-1:0]   ram_wdata,
    output logic [PTR_W-1:0]            ram_raddr,
    input  logic [THREAD_ID_BITS-1:0]   ram_rdata,
    output logic                        res_valid,
    output csfw_pkg::out_t              res_item,
    input  logic                        res_free
);
    import csfw_pkg::*;

    localparam int TOTAL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]      LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [TOTAL_W-1:0]    TOTAL_FULL = TOTAL_W'(QUEUE_DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [STATUS_W-1:0]     pend_status_reg, pend_status_next;
    logic                    pend_wake_reg, pend_wake_next;
    logic                    accept;
    logic [THREAD_ID_BITS-1:0] tid;

    assign tid      = THREAD_ID_BITS'(in_item.thread_id);
    assign accept   = in_valid && (state_reg == S_IDLE) && res_free;
    assign in_stall = (state_reg != S_IDLE) || !res_free;

    // The head entry is read every cycle; it is used only on the cycle after a wake-up transfer.
    assign ram_raddr = head_reg;
    assign ram_waddr = tail_reg;
    assign ram_wdata = tid;

    // Request decode and state update.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        total_next       = total_reg;
        pend_status_next = pend_status_reg;
        pend_wake_next   = pend_wake_reg;
        ram_we           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next     = S_LOOKUP;
                    pend_wake_next = 1'b0;
                    if (in_item.command == CMD_WAIT)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next       = count_reg - 1'b1;
                            pend_status_next = STATUS_GRANTED;
                        end
                        else if (total_reg != TOTAL_FULL)
                        begin
                            ram_we           = 1'b1;
                            tail_next        = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                            total_next       = total_reg + 1'b1;
                            pend_status_next = STATUS_BLOCKED;
                        end
                        else
                        begin
                            pend_status_next = STATUS_QFULL;
                        end
                    end
                    else
                    begin
                        if (total_reg != '0)
                        begin
                            head_next        = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                            total_next       = total_reg - 1'b1;
                            pend_wake_next   = 1'b1;
                            pend_status_next = STATUS_WOKEN;
                        end
                        else if (count_reg == COUNT_MAX)
                        begin
                            pend_status_next = STATUS_SATURATED;
                        end
                        else
                        begin
                            count_next       = count_reg + 1'b1;
                            pend_status_next = STATUS_RELEASED;
                        end
                    end
                end
            end
            S_LOOKUP:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A register write re-initialises the count and empties the queue.
        if (cfg_write_en)
        begin
            count_next = COUNT_BITS'(cfg_write_data);
            head_next  = '0;
            tail_next  = '0;
            total_next = '0;
        end
    end

    // Result assembly once the head entry has been read.
    always_comb
    begin
        res_valid                = (state_reg == S_LOOKUP);
        res_item.status          = pend_status_reg;
        res_item.woken_thread    = pend_wake_reg ? ID_W'(ram_rdata) : '0;
        res_item.count_now       = COUNT_W'(count_reg);
        res_item.waiters_now     = WAITERS_W'(total_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            total_reg <= total_next;
        end
    end

    // Pending result fields carry no reset.
    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_wake_reg   <= pend_wake_next;
    end

endmodule

// ===== rtl/csfw_out_stage.sv =====
// Output register that holds a result until the receiving side takes the transfer.
module csfw_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    input  csfw_pkg::out_t res_item,
    output logic           res_free,
    output logic           out_valid,
    input  logic           out_stall,
    output csfw_pkg::out_t out_item
);
    import csfw_pkg::*;

    logic out_valid_reg, out_valid_next;
    out_t out_item_reg, out_item_next;
    logic load;

    assign res_free = !out_valid_reg || !out_stall;
    assign load     = res_valid && res_free;

    // Load a new result or drop the one just taken.
    always_comb
    begin
        out_item_next = out_item_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res_item;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/counting_semaphore_fifo_waiters_top.sv =====
// Top level of the counting semaphore with a first-in first-out queue of waiters.
//
//   Channel   Direction  Handshake                   Payload
//   in        request    in_valid / in_stall         in_item (command, thread_id)
//   out       result     out_valid / out_stall       out_item (status, woken_thread,
//                                                    count_now, waiters_now)
//   cfg       write      cfg_write_en                cfg_write_data (initial_count)
//
// Each request updates the count and queue pointers and addresses the waiter store in
// S_IDLE, then waits in S_LOOKUP for the registered read of the head entry.
// A result is loaded into the output register at the edge after its request transfer.
// Reset empties the queue and clears the count; the waiter store needs no clearing pass.
// While a result is stalled at the output the next request is held off.
module counting_semaphore_fifo_waiters_top #(
    parameter int QUEUE_DEPTH    = csfw_pkg::DEF_QUEUE_DEPTH,
    parameter int THREAD_ID_BITS = csfw_pkg::DEF_THREAD_ID_BITS,
    parameter int COUNT_BITS     = csfw_pkg::DEF_COUNT_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  csfw_pkg::in_t              in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output csfw_pkg::out_t             out_item,
    input  logic                       cfg_write_en,
    input  logic [csfw_pkg::CFG_W-1:0] cfg_write_data
);
    import csfw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic                      ram_we;
    logic [PTR_W-1:0]          ram_waddr;
    logic [THREAD_ID_BITS-1:0] ram_wdata;
    logic [PTR_W-1:0]          ram_raddr;
    logic [THREAD_ID_BITS-1:0] ram_rdata;
    logic                      res_valid;
    out_t                      res_item;
    logic                      res_free;

    // Waiter store.
    csfw_ram #(
        .WIDTH (THREAD_ID_BITS),
        .DEPTH (QUEUE_DEPTH),
        .ADDR_W(PTR_W)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Count and queue control.
    csfw_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .THREAD_ID_BITS(THREAD_ID_BITS),
        .COUNT_BITS    (COUNT_BITS),
        .PTR_W         (PTR_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_item       (in_item),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .res_valid     (res_valid),
        .res_item      (res_item),
        .res_free      (res_free)
    );

    // Result register.
    csfw_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_valid(res_valid),
        .res_item (res_item),
        .res_free (res_free),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

endmodule

// ===== rtl/csfw_checker.sv =====
// Port-level checker for the semaphore top level, with its bind statement.
`include "counting_semaphore_fifo_waiters_top_assert.svh"

module csfw_checker #(
    parameter int QUEUE_DEPTH = csfw_pkg::DEF_QUEUE_DEPTH
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input csfw_pkg::out_t out_item,
    input logic           out_valid,
    input logic           out_stall
);
    import csfw_pkg::*;

    // A woken identifier is reported only with the wake-up status.
    `CSFW_ASSERT_SAME(woken_only_on_wake, out_valid && (out_item.status != STATUS_WOKEN), out_item.woken_thread == '0)

    // A blocked wait can only have found the count at zero.
    `CSFW_ASSERT_SAME(blocked_needs_zero, out_valid && (out_item.status == STATUS_BLOCKED), (out_item.count_now == '0) && (out_item.waiters_now != '0))

    // The number of waiters never exceeds the queue depth.
    `CSFW_ASSERT_SAME(waiters_bounded, out_valid, out_item.waiters_now <= WAITERS_W'(QUEUE_DEPTH))

    // A new result appears only after a request transfer has passed the control state and output registers.
    `CSFW_ASSERT_SAME(result_follows_request, $rose(out_valid), $past(in_valid && !in_stall, 2))

    // A stalled result is not dropped.
    `CSFW_ASSERT_NEXT(stalled_result_kept, out_valid && out_stall, out_valid)

endmodule

bind counting_semaphore_fifo_waiters_top csfw_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_csfw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_item (out_item),
    .out_valid(out_valid),
    .out_stall(out_stall)
);
